### design/opbf_pkg.sv
package opbf_pkg;

    // Widths of the character, code word, length register and length header.
    localparam int CharW   = 7;
    localparam int CodeW   = 8;
    localparam int LenW    = 16;
    localparam int PosW    = 7;

    // Synchronous idle character that opens every block header.
    localparam logic [CharW-1:0] SynChar = 7'd22;

    // Word slot of the item held in the input register, one-hot.
    typedef enum logic [3:0] {
        PH_SYN0 = 4'b0001,
        PH_SYN1 = 4'b0010,
        PH_LEN  = 4'b0100,
        PH_DATA = 4'b1000
    } t_phase;

    // Odd parity coding: bit 0 is set when the seven data bits hold an even
    // number of ones, bits 1 to 7 carry the data least significant first.
    function automatic logic [CodeW-1:0] encode_word(input logic [CharW-1:0] d);
        encode_word = {d, ~(^d)};
    endfunction

endpackage

### design/odd_parity_block_framer_core.sv
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_character
// result    out        o_out_valid / i_out_stall o_code_word, o_last_of_run
// config    in         i_cfg_wr_en               i_cfg_wr_data (message length)
//
// Inside a block: one code word per clock while i_out_stall is low.
// A character that opens a block is held in the input register while the two
// SYN words, the length word and its data leave one at a time through the
// output register.
// Reset is synchronous and active low; it clears the message counters and
// both valid flags. A stall on the result side holds the output register and,
// once the input register is full too, raises o_in_stall.
module odd_parity_block_framer_core #(
    parameter int BLOCK_SIZE = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [opbf_pkg::LenW-1:0]     i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [opbf_pkg::CharW-1:0]    i_character,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [opbf_pkg::CodeW-1:0]    o_code_word,
    output logic                          o_last_of_run
);

    localparam logic [opbf_pkg::PosW-1:0] BlockSizeP = opbf_pkg::PosW'(BLOCK_SIZE);
    localparam logic [opbf_pkg::LenW-1:0] BlockSizeL = opbf_pkg::LenW'(BLOCK_SIZE);

    // Configuration register.
    logic [opbf_pkg::LenW-1:0]  r_message_length;

    // Message state.
    logic [opbf_pkg::LenW-1:0]  r_chars_rem, n_chars_rem;
    logic [opbf_pkg::PosW-1:0]  r_block_pos, n_block_pos;

    // Input register: one accepted character and its pending words.
    logic                       r_busy, n_busy;
    opbf_pkg::t_phase           r_phase, n_phase;
    logic [opbf_pkg::CharW-1:0] r_char;
    logic [opbf_pkg::PosW-1:0]  r_len;

    // Output register.
    logic                       r_out_valid, n_out_valid;
    logic [opbf_pkg::CodeW-1:0] r_code, n_code;
    logic                       r_last, n_last;

    logic                       out_free;
    logic                       advance;
    logic                       in_acc;
    logic                       start;
    logic                       drop;
    logic [opbf_pkg::LenW-1:0]  rem_eff;
    logic [opbf_pkg::PosW-1:0]  pos_eff;
    logic [opbf_pkg::LenW-1:0]  rem_dec;
    logic [opbf_pkg::PosW-1:0]  pos_inc;
    logic                       hdr;
    logic [opbf_pkg::PosW-1:0]  hdr_len;
    logic                       load;

    // Handshake decisions.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_busy && out_free;
    assign o_in_stall = r_busy && !(out_free && (r_phase == opbf_pkg::PH_DATA));
    assign in_acc     = i_in_valid && !o_in_stall;

    // Block bookkeeping for the incoming character.
    always_comb begin
        start   = (r_chars_rem == '0);
        rem_eff = start ? r_message_length : r_chars_rem;
        pos_eff = start ? '0 : r_block_pos;
        drop    = (rem_eff == '0);
        hdr     = (pos_eff == '0);
        hdr_len = (rem_eff < BlockSizeL) ? rem_eff[opbf_pkg::PosW-1:0] : BlockSizeP;
        rem_dec = rem_eff - opbf_pkg::LenW'(1);
        pos_inc = pos_eff + opbf_pkg::PosW'(1);
        load    = in_acc && !drop;

        n_chars_rem = r_chars_rem;
        n_block_pos = r_block_pos;
        if (in_acc) begin
            if (drop) begin
                n_chars_rem = '0;
                n_block_pos = '0;
            end else begin
                n_chars_rem = rem_dec;
                n_block_pos = ((pos_inc >= BlockSizeP) || (rem_dec == '0)) ? '0 : pos_inc;
            end
        end
    end

    // Input register sequencing through the header and data words.
    always_comb begin
        n_busy  = r_busy;
        n_phase = r_phase;
        if (load) begin
            n_busy  = 1'b1;
            n_phase = hdr ? opbf_pkg::PH_SYN0 : opbf_pkg::PH_DATA;
        end else if (advance) begin
            case (r_phase)
                opbf_pkg::PH_SYN0: n_phase = opbf_pkg::PH_SYN1;
                opbf_pkg::PH_SYN1: n_phase = opbf_pkg::PH_LEN;
                opbf_pkg::PH_LEN:  n_phase = opbf_pkg::PH_DATA;
                opbf_pkg::PH_DATA: n_busy  = 1'b0;
                default:           n_phase = opbf_pkg::PH_DATA;
            endcase
        end
    end

    // Output register contents.
    always_comb begin
        n_out_valid = r_out_valid;
        n_code      = r_code;
        n_last      = r_last;
        if (advance) begin
            n_out_valid = 1'b1;
            n_last      = (r_phase == opbf_pkg::PH_DATA);
            case (r_phase)
                opbf_pkg::PH_SYN0: n_code = opbf_pkg::encode_word(opbf_pkg::SynChar);
                opbf_pkg::PH_SYN1: n_code = opbf_pkg::encode_word(opbf_pkg::SynChar);
                opbf_pkg::PH_LEN:  n_code = opbf_pkg::encode_word(r_len);
                opbf_pkg::PH_DATA: n_code = opbf_pkg::encode_word(r_char);
                default:           n_code = opbf_pkg::encode_word(r_char);
            endcase
        end else if (out_free) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_message_length <= '0;
            r_chars_rem      <= '0;
            r_block_pos      <= '0;
            r_busy           <= 1'b0;
            r_phase          <= opbf_pkg::PH_DATA;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_message_length <= i_cfg_wr_data;
            end
            r_chars_rem <= n_chars_rem;
            r_block_pos <= n_block_pos;
            r_busy      <= n_busy;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= i_character;
            r_len  <= hdr_len;
        end
        r_code <= n_code;
        r_last <= n_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_code_word   = r_code;
    assign o_last_of_run = r_last;

    // A header word on the output means its data word is still held upstream.
    a_hdr_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_of_run |-> r_busy)
        else $error("header word shown without its character held");

    // The length word always names a non-empty block no longer than the limit.
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_phase == opbf_pkg::PH_LEN) |=>
            (o_code_word[opbf_pkg::CodeW-1:1] != '0) &&
            (o_code_word[opbf_pkg::CodeW-1:1] <= BlockSizeP))
        else $error("length header out of range");

    // The block position stays inside a block.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_block_pos < BlockSizeP)
        else $error("block position past block size");

    // A block in progress implies characters are still owed.
    a_pos_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_block_pos != '0) |-> (r_chars_rem != '0))
        else $error("open block with no characters remaining");

    // The input side only stalls while a transaction is held.
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_busy)
        else $error("input stalled with empty input register");

endmodule
